[hdl/tds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared definitions of the sample store
// Payload structs, command and status codes, register indexes, and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DIMS_DEF     = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_NEAR    = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DEDUP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_DIM0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_DIM1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_DIM2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_DIM3   = 3'd5;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [5:0]   entry_index;
    logic signed [15:0] label_in;
    logic signed [15:0] feat0_in;
    logic signed [15:0] feat1_in;
    logic signed [15:0] feat2_in;
    logic signed [15:0] feat3_in;
  } item_t;

  typedef struct packed {
    logic [2:0]   status;
    logic [6:0]   stored_count;
    logic signed [15:0] label_out;
    logic signed [15:0] feat0_out;
    logic signed [15:0] feat1_out;
    logic signed [15:0] feat2_out;
    logic signed [15:0] feat3_out;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_en;
    logic       read_issue;
    logic       emit;
    logic [2:0] emit_status;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       dedup_on;
    logic       count_zero;
    logic       scan_done;
    logic       dup;
    logic       out_free;
  } ctl_stat_t;

endpackage

[hdl/tds_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample store controller
// Sequences one item at a time: capture, decode, a scan or a read where needed, and result.
// ----------------------------------------------------------------------------
module tds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  tds_pkg::ctl_stat_t stat,
  output tds_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_READ,
    S_RESULT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] res_status;
  logic [2:0] res_status_next;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = '0;
    cmd.emit_status = res_status;
    item_ready      = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          tds_pkg::CMD_ADD: begin
            if (stat.full) begin
              res_status_next = tds_pkg::ST_FULL;
              state_next      = S_RESULT;
            end else if (stat.dedup_on && !stat.count_zero) begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end else begin
              res_status_next = tds_pkg::ST_ADDED;
              state_next      = S_RESULT;
            end
          end
          tds_pkg::CMD_CLEAR: begin
            res_status_next = tds_pkg::ST_CLEARED;
            state_next      = S_RESULT;
          end
          default: begin
            state_next = S_READ;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          res_status_next = stat.dup ? tds_pkg::ST_NEAR : tds_pkg::ST_ADDED;
          state_next      = S_RESULT;
        end
      end
      S_READ: begin
        cmd.read_issue  = 1'b1;
        res_status_next = tds_pkg::ST_READ;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= tds_pkg::ST_ADDED;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

[hdl/tds_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample store datapath
// Configuration registers, item register, example memory, scan comparator,
// entry count and the result register.
// ----------------------------------------------------------------------------
module tds_datapath #(
  parameter int CAPACITY = tds_pkg::CAPACITY_DEF,
  parameter int DIMS     = tds_pkg::DIMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  tds_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output tds_pkg::result_t                 result,
  input  tds_pkg::ctl_cmd_t                cmd,
  output tds_pkg::ctl_stat_t               stat
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WW = (CW > 7) ? CW : 7;
  localparam int MW = 16 * (DIMS + 1);

  // Configuration registers.
  logic        dedup_mode;
  logic [6:0]  capacity_limit;
  logic [14:0] tol [4];

  // Item and store state.
  tds_pkg::item_t item_r;
  logic [CW-1:0]  entry_count;
  logic [CW-1:0]  scan_addr;
  logic           rd_pending;
  logic           dup;
  logic           rd_ok;
  logic [MW-1:0]  mem [CAPACITY];
  logic [MW-1:0]  rd_data;

  logic [WW-1:0] cap_w;
  logic [WW-1:0] eff_cap;
  logic [WW-1:0] count_w;
  logic [WW-1:0] idx_w;
  logic          idx_ok;
  logic          issue;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [63:0]   feat_vec;
  logic [MW-1:0] wr_data;
  logic          wr_en;
  logic          near;
  logic [CW-1:0] count_after;
  logic [WW-1:0] count_after_w;
  logic [63:0]   out_feats;
  logic [15:0]   out_label;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dedup_mode     <= 1'b1;
      capacity_limit <= 7'd64;
      for (int d = 0; d < 4; d++) begin
        tol[d] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        tds_pkg::REG_DEDUP_MODE: dedup_mode     <= cfg_data[0];
        tds_pkg::REG_CAPACITY:   capacity_limit <= cfg_data[6:0];
        tds_pkg::REG_TOL_DIM0:   tol[0]         <= cfg_data;
        tds_pkg::REG_TOL_DIM1:   tol[1]         <= cfg_data;
        tds_pkg::REG_TOL_DIM2:   tol[2]         <= cfg_data;
        tds_pkg::REG_TOL_DIM3:   tol[3]         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capacity above the store size acts as the store size.
  assign cap_w   = WW'(CAPACITY);
  assign eff_cap = (WW'(capacity_limit) < cap_w) ? WW'(capacity_limit) : cap_w;
  assign count_w = WW'(entry_count);
  assign idx_w   = WW'(item_r.entry_index);
  assign idx_ok  = (idx_w < count_w) && (idx_w < cap_w);

  assign feat_vec = {item_r.feat3_in, item_r.feat2_in, item_r.feat1_in, item_r.feat0_in};

  // Scan issues one memory read a cycle; the compare sees it in the next cycle.
  assign issue   = cmd.scan_en && (scan_addr < entry_count) && !dup;
  assign rd_en   = cmd.read_issue || issue;
  assign rd_addr = cmd.read_issue ? idx_w[AW-1:0] : scan_addr[AW-1:0];

  always_comb begin
    near = 1'b1;
    for (int d = 0; d < DIMS; d++) begin
      logic signed [16:0] diff;
      logic [16:0]        mag;
      diff = 17'(signed'(feat_vec[16*d +: 16])) - 17'(signed'(rd_data[16*(d+1) +: 16]));
      mag  = diff[16] ? 17'(-diff) : 17'(diff);
      if (mag > {2'b00, tol[d]}) begin
        near = 1'b0;
      end
    end
  end

  always_comb begin
    wr_data         = '0;
    wr_data[15:0]   = item_r.label_in;
    for (int d = 0; d < DIMS; d++) begin
      wr_data[16*(d+1) +: 16] = feat_vec[16*d +: 16];
    end
  end

  assign wr_en = cmd.emit && (cmd.emit_status == tds_pkg::ST_ADDED);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[entry_count[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
    if (cmd.read_issue) begin
      rd_ok <= idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      scan_addr   <= '0;
      rd_pending  <= 1'b0;
      dup         <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_addr  <= '0;
        rd_pending <= 1'b0;
        dup        <= 1'b0;
      end else if (cmd.scan_en) begin
        rd_pending <= issue;
        if (issue) begin
          scan_addr <= scan_addr + 1'b1;
        end
        if (rd_pending && near) begin
          dup <= 1'b1;
        end
      end
      if (cmd.emit) begin
        entry_count <= count_after;
      end
    end
  end

  always_comb begin
    case (cmd.emit_status)
      tds_pkg::ST_ADDED:   count_after = entry_count + 1'b1;
      tds_pkg::ST_CLEARED: count_after = '0;
      default:             count_after = entry_count;
    endcase
  end
  assign count_after_w = WW'(count_after);

  // Read data is returned only for an entry below the count; else zero.
  always_comb begin
    out_label = '0;
    out_feats = '0;
    if ((cmd.emit_status == tds_pkg::ST_READ) && rd_ok) begin
      out_label = rd_data[15:0];
      for (int d = 0; d < DIMS; d++) begin
        out_feats[16*d +: 16] = rd_data[16*(d+1) +: 16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status       <= cmd.emit_status;
      result.stored_count <= count_after_w[6:0];
      result.label_out    <= out_label;
      result.feat0_out    <= out_feats[15:0];
      result.feat1_out    <= out_feats[31:16];
      result.feat2_out    <= out_feats[47:32];
      result.feat3_out    <= out_feats[63:48];
    end
  end

  assign stat.cmd        = item_r.cmd;
  assign stat.full       = (count_w >= eff_cap);
  assign stat.dedup_on   = dedup_mode;
  assign stat.count_zero = (entry_count == '0);
  assign stat.scan_done  = dup || (!issue && !rd_pending);
  assign stat.dup        = dup;
  assign stat.out_free   = !result_valid || result_ready;

  // The count never passes the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= cap_w)
    else $error("entry count beyond store size");

  // While a scan runs, its pointer never runs past the held entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_en |-> scan_addr <= entry_count)
    else $error("scan pointer beyond entry count");

  // An accepted add grows the store by exactly one entry.
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> entry_count == $past(entry_count) + 1'b1)
    else $error("add did not advance the entry count");

endmodule

[hdl/tolerance_dedup_sample_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Near-duplicate rejecting sample store
// Holds labelled examples of Q8.8 features and refuses adds that are full or,
// in uniform mode, within tolerance of a stored example.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the item channel (valid/ready) and each gives exactly
// one transfer on the result channel. Configuration registers are written on
// the cfg channel, which is always ready; write them only while the block is
// idle. Register 0 selects uniform mode, 1 the capacity, 2 to 5 the tolerance
// of each feature; an index beyond these is ignored.
// Timing. The block works on one item at a time. An add in uniform mode scans
// the stored examples through the single memory read port, one a cycle; a scan
// meets at most 63 held entries, since a full store is refused first, and a
// near duplicate ends the scan early. The next item is taken once the result
// has been loaded into the output register and the block is back in idle.
// Reset returns the configuration and control registers to their documented
// values and empties the store; the item and result registers are not reset,
// and the example memory is not cleared, since entries beyond the count are
// never returned. The result sits in an output register: a new item is taken
// while it waits, and the block holds its next result until that one is taken.
// ----------------------------------------------------------------------------
module tolerance_dedup_sample_store_top #(
  parameter int CAPACITY = tds_pkg::CAPACITY_DEF,
  parameter int DIMS     = tds_pkg::DIMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  tds_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output tds_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Controller and datapath talk only through these two groups.
  tds_pkg::ctl_cmd_t  cmd;
  tds_pkg::ctl_stat_t stat;

  tds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath owns the memory, the count and the result register.
  tds_datapath #(
    .CAPACITY (CAPACITY),
    .DIMS     (DIMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
